// ===== rtl/sm3_hash_engine_defines.svh =====
// ----------------------------------------------------------------------------
// SM3 hash engine assertion macros
// Property wrappers for the engine's assertions.
// ----------------------------------------------------------------------------
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH

// Implication checked on every edge outside reset.
`define SM3_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SM3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// SM3 package
// Constants, types and round functions shared by the engine modules.
// ----------------------------------------------------------------------------
package sm3_pkg;

    localparam int WordWidth  = 32;
    localparam int BlockWords = 16;
    localparam int Rounds     = 64;

    localparam logic [31:0] TLow   = 32'h79cc4519;
    localparam logic [31:0] THigh  = 32'h7a879d8a;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef logic [31:0] t_word;

    localparam t_word Iv [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    // Control from the sequencer to the compression core.
    typedef struct packed {
        logic       start;
        logic [5:0] round;
    } t_core_ctl;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ===== rtl/sm3_hash_engine.sv =====
// A word that completes no block is accepted while idle; each block compression
// runs load, 64 rounds and chain update, with o_stall high throughout.
// A last word adds up to 18 padding writes and 1 or 2 compressions, then
// the eight digest words, which hold while the output is stalled.
// No new word is taken during padding, compression or digest output.
// Reset (synchronous, active low) loads the initial chaining value and clears control state, not r_buf.
// ----------------------------------------------------------------------------
// SM3 hash engine
// Buffers words, pads the message and drives the compression core.
// ----------------------------------------------------------------------------
`include "sm3_hash_engine_defines.svh"
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_CHAIN = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    t_word       r_buf [BlockWords];
    t_word       r_chain [8];
    logic [63:0] r_len;
    logic [3:0]  r_fill;
    logic [6:0]  r_round;
    logic [1:0]  r_pad;    // words of padding pending before zero fill: 80 word
    // r_padding marks a message in its padding phase; r_fin marks the final block.
    logic        r_padding;
    logic        r_fin;
    logic [2:0]  r_oidx;
    logic        r_ovalid;
    t_word       core_regs [8];
    t_core_ctl   ctl;
    t_word       wr_word;
    logic        wr_en;
    logic        acc;
    t_word       lw;
    logic [2:0]  nb;
    logic [63:0] len_add;

    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign ctl.start = (r_state == S_ROUND) && (r_round == 7'd0);
    assign ctl.round = r_round[5:0] - 6'd1;

    sm3_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .i_blk  (r_buf),
        .i_chain(r_chain),
        .o_regs (core_regs)
    );

    always_comb begin
        nb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
        unique case (nb)
            3'd0:    lw = {PadByte, 24'h0};
            3'd1:    lw = {i_data_word[31:24], PadByte, 16'h0};
            3'd2:    lw = {i_data_word[31:16], PadByte, 8'h0};
            3'd3:    lw = {i_data_word[31:8], PadByte};
            default: lw = i_data_word;
        endcase
        len_add = i_last_word ? {58'd0, nb, 3'd0} : 64'd32;
        wr_en   = 1'b0;
        wr_word = i_data_word;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc) begin
                wr_en   = 1'b1;
                wr_word = i_last_word ? lw : i_data_word;
                if (r_fill == 4'd15) n_state = S_ROUND;
                else if (i_last_word) n_state = S_PAD;
            end
            S_PAD: begin
                wr_en = 1'b1;
                if (r_pad != 2'd0) wr_word = {PadByte, 24'h0};
                else if (r_fill == 4'd14 && !r_padding) wr_word = r_len[63:32];
                else if (r_fill == 4'd15 && !r_padding) wr_word = r_len[31:0];
                else wr_word = '0;
                if (r_fill == 4'd15) n_state = S_ROUND;
            end
            S_ROUND: if (r_round == 7'd64) n_state = S_CHAIN;
            S_CHAIN: begin
                if (r_fin) n_state = S_OUT;
                else if (r_padding || r_pad != 2'd0) n_state = S_PAD;
                else n_state = S_IDLE;
            end
            S_OUT: if (!i_stall && r_oidx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_buf[r_fill] <= wr_word;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_fill    <= '0;
            r_round   <= '0;
            r_pad     <= '0;
            r_padding <= 1'b0;
            r_fin     <= 1'b0;
            r_oidx    <= '0;
            r_ovalid  <= 1'b0;
            for (int k = 0; k < 8; k++) r_chain[k] <= Iv[k];
        end else begin
            r_state  <= n_state;
            r_ovalid <= (n_state == S_OUT);
            if (wr_en) r_fill <= r_fill + 4'd1;
            unique case (r_state)
                S_IDLE: if (acc) begin
                    r_len <= r_len + len_add;
                    if (i_last_word) begin
                        r_pad     <= (nb == 3'd4) ? 2'd1 : 2'd0;
                        // A short last word in slot 13 leaves room for the length.
                        r_padding <= !(r_fill == 4'd13 && nb != 3'd4);
                    end
                end
                S_PAD: begin
                    if (r_pad != 2'd0) r_pad <= r_pad - 2'd1;
                    else if (r_fill == 4'd13 && r_padding) r_padding <= 1'b0;
                    else if (r_fill == 4'd15 && !r_padding) r_fin <= 1'b1;
                    // A pending 80 word landing on slot 13 leaves room for length.
                    if (r_pad != 2'd0 && r_fill == 4'd13) r_padding <= 1'b0;
                    // Fill past slot 13 while still padding forces an extra block.
                end
                S_ROUND: r_round <= (r_round == 7'd64) ? 7'd0 : r_round + 7'd1;
                S_CHAIN: begin
                    for (int k = 0; k < 8; k++) r_chain[k] <= r_chain[k] ^ core_regs[k];
                    r_fin <= 1'b0;
                end
                S_OUT: if (!i_stall) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        for (int k = 0; k < 8; k++) r_chain[k] <= Iv[k];
                        r_len     <= '0;
                        r_fill    <= '0;
                        r_padding <= 1'b0;
                        r_pad     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_chain[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_digest_last = (r_oidx == 3'd7);

    `SM3_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall, "accept while busy")
    `SM3_ASSERT_IMPL(a_round_range, i_clk, i_rst_n, 1'b1, r_round <= 7'd64, "round overrun")
    `SM3_ASSERT_NEXT(a_out_idx, i_clk, i_rst_n, o_valid && !i_stall && r_oidx != 3'd7, r_oidx == $past(r_oidx) + 3'd1, "digest index skip")
endmodule

// ===== rtl/sm3_core.sv =====
// ----------------------------------------------------------------------------
// SM3 compression core
// One round per cycle over a 16-word sliding expansion window.
// ----------------------------------------------------------------------------
module sm3_core
    import sm3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_word     i_blk [BlockWords],
    input  t_word     i_chain [8],
    output t_word     o_regs [8]
);
    t_word r_w [BlockWords];
    t_word r_v [8];
    t_word n_w [BlockWords];
    t_word n_v [8];
    t_word w_new, a12, ss1, ss2, ffv, ggv, tt1, tt2, tj;
    logic  early;

    always_comb begin
        w_new = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15))
                ^ rotl(r_w[3], 5'd7) ^ r_w[10];
        early = (i_ctl.round < 6'd16);
        tj    = early ? TLow : THigh;
        a12   = rotl(r_v[0], 5'd12);
        ss1   = rotl(a12 + r_v[4] + rotl(tj, i_ctl.round[4:0]), 5'd7);
        ss2   = ss1 ^ a12;
        ffv   = early ? (r_v[0] ^ r_v[1] ^ r_v[2])
                      : ((r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]));
        ggv   = early ? (r_v[4] ^ r_v[5] ^ r_v[6])
                      : ((r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]));
        tt1   = ffv + r_v[3] + ss2 + (r_w[0] ^ r_w[4]);
        tt2   = ggv + r_v[7] + ss1 + r_w[0];
        if (i_ctl.start) begin
            n_w = i_blk;
            n_v = i_chain;
        end else begin
            for (int k = 0; k < BlockWords - 1; k++) n_w[k] = r_w[k+1];
            n_w[BlockWords-1] = w_new;
            n_v[0] = tt1;
            n_v[1] = r_v[0];
            n_v[2] = rotl(r_v[1], 5'd9);
            n_v[3] = r_v[2];
            n_v[4] = perm0(tt2);
            n_v[5] = r_v[4];
            n_v[6] = rotl(r_v[5], 5'd19);
            n_v[7] = r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_v[k] <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_regs = r_v;
endmodule
